### src/vdh_pkg.sv
// Shared constants for the vertex degree histogram.
package vdh_pkg;

  localparam int NUM_BINS_DEF    = 4096;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int VERTEX_WIDTH = 16;
  localparam int REQ_WIDTH    = 2;
  localparam int OUT_WIDTH    = 32;

  localparam logic [REQ_WIDTH-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_CLEAR = 2'd2;

endpackage

### src/vertex_degree_histogram.sv
// Top level of the vertex degree histogram: per-vertex counts in RAM, running maxima.
// The count RAM is read when an item is accepted; the update, the write back and the
// output register follow in the calc state, which waits while the output is stalled.
// No new item is accepted until the read-modify-write of the count RAM is done.
// Reset and every clear request start a sweep that zeroes the
// count RAM one entry per cycle; no item is accepted until the sweep ends.
module vertex_degree_histogram #(
  parameter int NUM_BINS    = vdh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = vdh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [vdh_pkg::VERTEX_WIDTH-1:0]  s_axis_tdata,  // [15:0] vertex
  input  logic [vdh_pkg::REQ_WIDTH-1:0]     s_axis_tuser,  // [1:0] req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [79:0]                       m_axis_tdata,  // [31:0] bin_count,
                                                           // [63:32] peak_degree,
                                                           // [79:64] peak_vertex
  output logic [0:0]                        m_axis_tuser   // [0] out_of_range
);

  import vdh_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int EW = COUNT_WIDTH + OUT_WIDTH;
  localparam logic [AW-1:0]          LAST_ADDR = AW'(NUM_BINS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           clr_addr_q;
  logic [REQ_WIDTH-1:0]    req_q;
  logic [VERTEX_WIDTH-1:0] vertex_q;
  logic                    oor_q;
  logic [COUNT_WIDTH-1:0]  largest_count_q, largest_count_d;
  logic [VERTEX_WIDTH-1:0] largest_index_q, largest_index_d;
  logic                    out_valid_q;
  logic [OUT_WIDTH-1:0]    out_bin_q, out_bin_d;
  logic [OUT_WIDTH-1:0]    out_max_q, out_max_d;
  logic [VERTEX_WIDTH-1:0] out_vtx_q;
  logic                    out_oor_q, out_oor_d;

  logic                    in_accept;
  logic                    in_oor;
  logic                    calc_go;
  logic                    is_clear;
  logic                    is_add;
  logic [COUNT_WIDTH-1:0]  rd_data;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic [COUNT_WIDTH-1:0]  bin_res;
  logic [EW-1:0]           bin_ext;
  logic [EW-1:0]           max_ext;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [COUNT_WIDTH-1:0]  ram_wdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_oor        = {1'b0, s_axis_tdata} >= 17'(NUM_BINS);
  assign calc_go       = (state_q == ST_CALC) && (!out_valid_q || m_axis_tready);

  assign is_clear = (req_q == REQ_CLEAR);
  assign is_add   = (req_q == REQ_ADD) && !oor_q;
  assign cnt_inc  = (rd_data == CNT_MAX) ? rd_data : rd_data + COUNT_WIDTH'(1);

  always_comb begin
    largest_count_d = largest_count_q;
    largest_index_d = largest_index_q;
    bin_res         = '0;
    out_oor_d       = 1'b0;
    if (is_clear) begin
      largest_count_d = '0;
      largest_index_d = '0;
    end else if (oor_q) begin
      out_oor_d = 1'b1;
    end else if (is_add) begin
      bin_res = cnt_inc;
      if (cnt_inc > largest_count_q) begin
        largest_count_d = cnt_inc;
      end
      if (vertex_q > largest_index_q) begin
        largest_index_d = vertex_q;
      end
    end else begin
      bin_res = rd_data;
    end
  end

  assign bin_ext   = {{OUT_WIDTH{1'b0}}, bin_res};
  assign max_ext   = {{OUT_WIDTH{1'b0}}, largest_count_d};
  assign out_bin_d = bin_ext[OUT_WIDTH-1:0];
  assign out_max_d = max_ext[OUT_WIDTH-1:0];

  assign ram_we    = (state_q == ST_CLEAR) || (calc_go && is_add);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : vertex_q[AW-1:0];
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : cnt_inc;

  vdh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS),
    .AW    (AW)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (s_axis_tdata[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_addr_q      <= '0;
      req_q           <= '0;
      vertex_q        <= '0;
      oor_q           <= 1'b0;
      largest_count_q <= '0;
      largest_index_q <= '0;
      out_valid_q     <= 1'b0;
      out_bin_q       <= '0;
      out_max_q       <= '0;
      out_vtx_q       <= '0;
      out_oor_q       <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !calc_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            req_q    <= s_axis_tuser;
            vertex_q <= s_axis_tdata;
            oor_q    <= in_oor;
            state_q  <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (calc_go) begin
            largest_count_q <= largest_count_d;
            largest_index_q <= largest_index_d;
            out_valid_q     <= 1'b1;
            out_bin_q       <= out_bin_d;
            out_max_q       <= out_max_d;
            out_vtx_q       <= largest_index_d;
            out_oor_q       <= out_oor_d;
            if (is_clear) begin
              clr_addr_q <= '0;
              state_q    <= ST_CLEAR;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_vtx_q, out_max_q, out_bin_q};
  assign m_axis_tuser  = out_oor_q;

endmodule

### src/vdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_vertex_degree_histogram.sv
// Self-checking testbench for the vertex degree histogram: directed table, then random items.
`timescale 1ns / 100ps

module tb_vertex_degree_histogram;
  import vdh_pkg::*;

  localparam int NUM_BINS    = NUM_BINS_DEF;
  localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
  localparam int IDX_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RAND_ITEMS  = 1030;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 16;
  localparam int MAX_REPORT  = 10;

  localparam logic [REQ_WIDTH-1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [OUT_WIDTH-1:0]    bin_count;
    logic [OUT_WIDTH-1:0]    peak_degree;
    logic [VERTEX_WIDTH-1:0] peak_vertex;
    logic                    oor;
  } hist_result_t;

  typedef struct packed {
    logic [REQ_WIDTH-1:0]    req;
    logic [VERTEX_WIDTH-1:0] vertex;
    bit                      typed;
    hist_result_t            want;
  } plan_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [VERTEX_WIDTH-1:0] s_axis_tdata = '0;  // [15:0] vertex
  logic [REQ_WIDTH-1:0]    s_axis_tuser = '0;  // [1:0] req_type
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [79:0]             m_axis_tdata;       // [31:0] bin_count, [63:32] peak_degree,
                                               // [79:64] peak_vertex
  logic [0:0]              m_axis_tuser;       // [0] out_of_range

  logic [COUNT_WIDTH-1:0]  degree_tbl [NUM_BINS];
  logic [COUNT_WIDTH-1:0]  top_degree;
  logic [VERTEX_WIDTH-1:0] top_vertex;

  hist_result_t            hist_expect_q [$];
  plan_row_t               plan [$];
  int                      n_fail = 0;
  int                      cycle_cnt = 0;
  bit                      quiet_src = 1'b0;
  bit                      quiet_sink = 1'b0;
  logic [VERTEX_WIDTH-1:0] last_vertex = '0;

  vertex_degree_histogram #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic clear_stats();
    foreach (degree_tbl[i]) degree_tbl[i] = '0;
    top_degree = '0;
    top_vertex = '0;
  endtask

  task automatic tally_request(input logic [REQ_WIDTH-1:0] req,
                               input logic [VERTEX_WIDTH-1:0] vtx,
                               output hist_result_t res);
    logic [COUNT_WIDTH-1:0] cnt;
    res = '0;
    if (req == REQ_CLEAR) begin
      clear_stats();
    end else if (int'(vtx) >= NUM_BINS) begin
      res.oor = 1'b1;
    end else if (req == REQ_ADD) begin
      cnt = degree_tbl[vtx[IDX_W-1:0]];
      if (cnt != '1) cnt = cnt + 1'b1;
      degree_tbl[vtx[IDX_W-1:0]] = cnt;
      if (cnt > top_degree) top_degree = cnt;
      if (vtx > top_vertex) top_vertex = vtx;
      res.bin_count = OUT_WIDTH'(cnt);
    end else begin
      res.bin_count = OUT_WIDTH'(degree_tbl[vtx[IDX_W-1:0]]);
    end
    res.peak_degree = OUT_WIDTH'(top_degree);
    res.peak_vertex = top_vertex;
  endtask

  task automatic add_row(input logic [REQ_WIDTH-1:0] req, input logic [VERTEX_WIDTH-1:0] vtx,
                         input bit typed, input logic [OUT_WIDTH-1:0] bc,
                         input logic [OUT_WIDTH-1:0] md, input logic [VERTEX_WIDTH-1:0] mv,
                         input logic oor);
    plan_row_t row;
    row.req    = req;
    row.vertex = vtx;
    row.typed  = typed;
    row.want   = '{bin_count: bc, peak_degree: md, peak_vertex: mv, oor: oor};
    plan.push_back(row);
  endtask

  task automatic push_item(input logic [REQ_WIDTH-1:0] req, input logic [VERTEX_WIDTH-1:0] vtx,
                           input bit typed, input hist_result_t want);
    int           idle;
    hist_result_t res;
    idle = quiet_src ? 0 : $urandom_range(0, 10);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vtx;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    tally_request(req, vtx, res);
    hist_expect_q.push_back(typed ? want : res);
    last_vertex = vtx;
  endtask

  function automatic logic [VERTEX_WIDTH-1:0] pick_vertex();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: pick_vertex = VERTEX_WIDTH'($urandom_range(0, 15));
      4, 5:       pick_vertex = last_vertex;
      6:          pick_vertex = VERTEX_WIDTH'($urandom_range(0, NUM_BINS - 1));
      7:          pick_vertex = VERTEX_WIDTH'($urandom_range(NUM_BINS, 65535));
      8:          pick_vertex = VERTEX_WIDTH'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       pick_vertex = '0;
          1:       pick_vertex = VERTEX_WIDTH'(NUM_BINS - 1);
          2:       pick_vertex = VERTEX_WIDTH'(NUM_BINS);
          default: pick_vertex = '1;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [REQ_WIDTH-1:0]    req;
    logic [VERTEX_WIDTH-1:0] vtx;
    int                      r;
    clear_stats();
    add_row(REQ_READ,  16'd0,     1, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'd0,     1, 1, 1, 0,    0);
    add_row(REQ_ADD,   16'd4095,  1, 1, 1, 4095, 0);
    add_row(REQ_ADD,   16'd4095,  1, 2, 2, 4095, 0);
    add_row(REQ_READ,  16'd4096,  1, 0, 2, 4095, 1);
    add_row(REQ_ADD,   16'd65535, 1, 0, 2, 4095, 1);
    add_row(REQ_SPARE, 16'd4095,  1, 2, 2, 4095, 0);
    add_row(REQ_READ,  16'd65535, 1, 0, 2, 4095, 1);
    add_row(REQ_ADD,   16'd1,     0, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'd1,     0, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'd1,     0, 0, 0, 0,    0);
    add_row(REQ_READ,  16'd1,     0, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'd4094,  0, 0, 0, 0,    0);
    add_row(REQ_SPARE, 16'd65535, 0, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'hAAAA,  0, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'h0555,  0, 0, 0, 0,    0);
    add_row(REQ_CLEAR, 16'd65535, 1, 0, 0, 0,    0);
    add_row(REQ_READ,  16'd4095,  1, 0, 0, 0,    0);
    add_row(REQ_READ,  16'd1,     1, 0, 0, 0,    0);
    add_row(REQ_ADD,   16'd2048,  1, 1, 1, 2048, 0);
    add_row(REQ_ADD,   16'd5,     0, 0, 0, 0,    0);
    add_row(REQ_CLEAR, 16'd0,     1, 0, 0, 0,    0);
    add_row(REQ_SPARE, 16'd0,     1, 0, 0, 0,    0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) push_item(plan[i].req, plan[i].vertex, plan[i].typed, plan[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        quiet_src  = ($urandom_range(0, 3) == 0);
        quiet_sink = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 1)       req = REQ_CLEAR;
      else if (r < 62) req = REQ_ADD;
      else if (r < 86) req = REQ_READ;
      else if (r < 93) req = REQ_SPARE;
      else             req = REQ_ADD;
      vtx = pick_vertex();
      push_item(req, vtx, 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (hist_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (n_fail == 0 && hist_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // sink: random stall before each result, none while quiet_sink is set
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = quiet_sink ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : result_check
    hist_result_t want;
    hist_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.bin_count   = m_axis_tdata[31:0];
      got.peak_degree = m_axis_tdata[63:32];
      got.peak_vertex = m_axis_tdata[79:64];
      got.oor         = m_axis_tuser[0];
      if (hist_expect_q.size() == 0) begin
        if (n_fail < MAX_REPORT)
          $display("tb: unexpected item bc=%0d md=%0d mv=%0d oor=%0b",
                   got.bin_count, got.peak_degree, got.peak_vertex, got.oor);
        n_fail <= n_fail + 1;
      end else begin
        want = hist_expect_q.pop_front();
        if (got.bin_count !== want.bin_count || got.peak_degree !== want.peak_degree ||
            got.peak_vertex !== want.peak_vertex || got.oor !== want.oor) begin
          if (n_fail < MAX_REPORT)
            $display(
              "tb: mismatch exp bc=%0d md=%0d mv=%0d oor=%0b got bc=%0d md=%0d mv=%0d oor=%0b",
              want.bin_count, want.peak_degree, want.peak_vertex, want.oor,
              got.bin_count, got.peak_degree, got.peak_vertex, got.oor);
          n_fail <= n_fail + 1;
        end
      end
    end
  end

endmodule

### vertex_degree_histogram.f
src/vdh_pkg.sv
src/vdh_ram.sv
src/vertex_degree_histogram.sv
tb/tb_vertex_degree_histogram.sv
